@@ hw/rtl/bcd_pkg.sv @@
// Package for the button click detector: state encoding, state codes,
// configuration register indexes and reset values. No dependencies.
package bcd_pkg;

  localparam int CfgW = 16;

  // Button state codes as they appear on the result port
  localparam logic [2:0] CODE_IDLE     = 3'd0;
  localparam logic [2:0] CODE_DEBOUNCE = 3'd1;
  localparam logic [2:0] CODE_SINGLE   = 3'd2;
  localparam logic [2:0] CODE_HELD     = 3'd3;
  localparam logic [2:0] CODE_WAIT     = 3'd4;
  localparam logic [2:0] CODE_DOUBLE   = 3'd5;
  localparam logic [2:0] CODE_LONG     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_DOUBLE   = 2'd2;

  localparam logic [CfgW-1:0] RST_DEBOUNCE = 16'd20;
  localparam logic [CfgW-1:0] RST_LONG     = 16'd1000;
  localparam logic [CfgW-1:0] RST_DOUBLE   = 16'd300;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DEBOUNCE = 7'b0000010,
    ST_SINGLE   = 7'b0000100,
    ST_HELD     = 7'b0001000,
    ST_WAIT     = 7'b0010000,
    ST_DOUBLE   = 7'b0100000,
    ST_LONG     = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ticks;
    logic [CfgW-1:0] long_press_ticks;
    logic [CfgW-1:0] double_click_ticks;
  } cfg_t;

  function automatic logic [2:0] state_code(state_e s);
    logic [2:0] c;
    case (s)
      ST_IDLE:     c = CODE_IDLE;
      ST_DEBOUNCE: c = CODE_DEBOUNCE;
      ST_SINGLE:   c = CODE_SINGLE;
      ST_HELD:     c = CODE_HELD;
      ST_WAIT:     c = CODE_WAIT;
      ST_DOUBLE:   c = CODE_DOUBLE;
      ST_LONG:     c = CODE_LONG;
      default:     c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/bcd_cfg.sv @@
// Configuration register file for the button click detector.
// Depends on bcd_pkg.
module bcd_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [bcd_pkg::CfgW-1:0] cfg_wdata_i,
  output bcd_pkg::cfg_t            cfg_o
);
  import bcd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks     <= RST_DEBOUNCE;
      cfg_q.long_press_ticks   <= RST_LONG;
      cfg_q.double_click_ticks <= RST_DOUBLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: cfg_q.debounce_ticks     <= cfg_wdata_i;
        CFG_LONG:     cfg_q.long_press_ticks   <= cfg_wdata_i;
        CFG_DOUBLE:   cfg_q.double_click_ticks <= cfg_wdata_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bcd_fsm.sv @@
// Button state machine with saturating elapsed-tick counter.
// Depends on bcd_pkg.
module bcd_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          pressed_i,
  input  bcd_pkg::cfg_t cfg_i,
  output logic [2:0]    state_o,
  output logic          changed_o
);
  import bcd_pkg::*;

  localparam int CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;

  state_e                 mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, tick;
  logic                   stamp;
  logic [CmpW-1:0]        t_c, deb_c, long_c, dbl_c;

  // advance first, sticking at all ones
  assign tick   = elapsed_q + COUNT_WIDTH'(~&elapsed_q);
  assign t_c    = CmpW'(tick);
  assign deb_c  = CmpW'(cfg_i.debounce_ticks);
  assign long_c = CmpW'(cfg_i.long_press_ticks);
  assign dbl_c  = CmpW'(cfg_i.double_click_ticks);

  always_comb begin
    mode_d = mode_q;
    stamp  = 1'b0;
    case (mode_q)
      ST_DEBOUNCE: begin
        if (!pressed_i) begin
          mode_d = ST_IDLE;
        end else if (t_c >= deb_c) begin
          mode_d = ST_SINGLE;
          stamp  = 1'b1;
        end
      end
      ST_SINGLE: begin
        mode_d = pressed_i ? ST_HELD : ST_IDLE;
      end
      ST_HELD: begin
        if (!pressed_i) begin
          mode_d = ST_WAIT;
          stamp  = 1'b1;
        end else if (t_c >= long_c) begin
          mode_d = ST_LONG;
          stamp  = 1'b1;
        end
      end
      ST_WAIT: begin
        if (pressed_i) begin
          if (t_c <= dbl_c) begin
            mode_d = ST_DOUBLE;
          end
        end else if (t_c > dbl_c) begin
          mode_d = ST_IDLE;
        end
      end
      ST_DOUBLE: begin
        mode_d = ST_IDLE;
      end
      ST_LONG: begin
        mode_d = pressed_i ? ST_LONG : ST_IDLE;
      end
      default: begin
        if (pressed_i) begin
          mode_d = ST_DEBOUNCE;
          stamp  = 1'b1;
        end else begin
          mode_d = ST_IDLE;
        end
      end
    endcase
  end

  assign elapsed_d = stamp ? '0 : tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ST_IDLE;
      elapsed_q <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign state_o   = state_code(mode_d);
  assign changed_o = (mode_d != mode_q);

endmodule

@@ hw/rtl/button_click_detector.sv @@
// Top level of the button click detector: input register, state update,
// result register and configuration port. Depends on bcd_pkg, bcd_cfg, bcd_fsm.
//
// Each input beat is one tick's sample of the button level; each sample gives
// exactly one result beat carrying the state code after that sample and a flag
// that marks a change. The block is a two-register pipeline: a sample lands in
// the input register, the state machine updates from it and the result goes to
// the output register. A new sample is taken every cycle while results are
// drained. A full output register stalls the update, and the input register
// then holds one more sample before ready drops. Registers (debounce, long
// press, double click window, all in ticks) are written through the plain
// write port; the user must write them only while the pipeline is empty, as
// the block itself does not enforce it.
module button_click_detector #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [bcd_pkg::CfgW-1:0] cfg_wdata_i,
  // sample channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     pressed_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               button_state_o,
  output logic                     state_changed_o
);
  import bcd_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q, pressed_q;
  logic       out_valid_q, changed_q;
  logic [2:0] state_q;
  logic       advance;
  logic [2:0] res_state;
  logic       res_changed;

  // the state machine steps when a held sample can move into a free result slot
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  bcd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcd_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .pressed_i (pressed_q),
    .cfg_i     (cfg),
    .state_o   (res_state),
    .changed_o (res_changed)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pressed_q <= pressed_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      state_q   <= res_state;
      changed_q <= res_changed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign button_state_o  = state_q;
  assign state_changed_o = changed_q;

`ifndef SYNTH
  // an empty result slot never blocks the sample side
  a_ready_when_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty result register");

  // a double click reaches the port as a change, and lasts one sample
  a_double_reported : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance && (res_state == CODE_DOUBLE)
      |=> out_valid_o && (button_state_o == CODE_DOUBLE) && state_changed_o
  ) else $error("double click result lost or unmarked");

  a_double_one_sample : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance && out_valid_o && (button_state_o == CODE_DOUBLE)
      |-> (res_state == CODE_IDLE)
  ) else $error("double click held for more than one sample");
`endif

endmodule
